/* design/lrka_pkg.sv */
`default_nettype none

package lrka_pkg;

  localparam int RING_DEGREE = 1024;
  localparam int MASK_POLYS  = 1;
  localparam int STORE_WORDS = (MASK_POLYS + 1) * RING_DEGREE;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  localparam int WORD_W     = 32;
  localparam int COEF_W     = 10;
  localparam int MIDX_W     = 10;
  localparam int SLOT_W     = 4;
  localparam int LVL_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_BODY_WR = 2'd1,
    OP_ACCUM   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_BITS    = 3'd0,
    CFG_LEVELS       = 3'd1,
    CFG_MASK_LENGTH  = 3'd2,
    CFG_USED_COEFS   = 3'd3,
    CFG_SAMPLE_COUNT = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_DIGIT,
    ST_MUL,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [4:0]  base_bits;
    logic [4:0]  levels;
    logic [10:0] mask_length;
    logic [10:0] used_coefficients;
    logic [4:0]  sample_count;
  } cfg_t;

  typedef struct packed {
    logic prep;
    logic load;
    logic step;
  } mac_cmd_t;

  function automatic logic [ADDR_W-1:0] word_addr(input logic poly,
                                                  input logic [COEF_W-1:0] coef);
    logic [ADDR_W-1:0] base;
    base = poly ? ADDR_W'(MASK_POLYS * RING_DEGREE) : '0;
    return base + ADDR_W'(coef);
  endfunction

endpackage

`default_nettype wire

/* design/lrka_if.sv */
`default_nettype none

interface lrka_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [lrka_pkg::WORD_W-1:0]     sample_value;
  logic [lrka_pkg::WORD_W-1:0]     key_word;
  logic [lrka_pkg::LVL_W-1:0]      level;
  logic [lrka_pkg::MIDX_W-1:0]     mask_index;
  logic [lrka_pkg::SLOT_W-1:0]     sample_slot;
  logic                            poly_index;
  logic [lrka_pkg::COEF_W-1:0]     coef_index;

  modport source (output valid, opcode, sample_value, key_word, level, mask_index,
                  sample_slot, poly_index, coef_index, input ready);
  modport sink   (input valid, opcode, sample_value, key_word, level, mask_index,
                  sample_slot, poly_index, coef_index, output ready);
endinterface

interface lrka_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [lrka_pkg::WORD_W-1:0] data_value;

  modport source (output valid, status, data_value, input ready);
  modport sink   (input valid, status, data_value, output ready);
endinterface

interface lrka_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lrka_pkg::CFG_IDX_W-1:0]  index;
  logic [lrka_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/lwe_to_rlwe_keyswitch_accumulator.sv */
`default_nettype none

// Key-switch accumulator for packing LWE samples into one ring ciphertext.
// in_ch carries one operation per transaction (clear, body write, accumulate
// term, read word); out_ch returns one status/word per operation; cfg_ch
// writes the five decomposition and range registers and is always ready.
// The store is one single-port RAM of (MASK_POLYS+1)*RING_DEGREE words.
// Path from input acceptance to out valid, through the state register:
//   range error or body write: DONE; read: FETCH, then DONE;
//   accumulate: FETCH, DIGIT, MUL, WRITE, DONE, MUL stepping once per bit of
//   the extracted digit (at most base_bits) in the shift-subtract multiply loop;
//   clear: the CLEAR sweep, one RAM word zeroed per cycle, then DONE.
// One operation is in flight at a time; in_ch.ready is high only when idle.
// After reset the block sweeps the whole store to zero with in_ch.ready low;
// configuration writes are taken meanwhile.
// A finished result sits in the output register; a new operation is accepted
// while it waits, and the next result holds until out_ch.ready frees it.
module lwe_to_rlwe_keyswitch_accumulator (
  input  wire logic clk,
  input  wire logic rst_n,
  lrka_in_if.sink   in_ch,
  lrka_out_if.source out_ch,
  lrka_cfg_if.sink  cfg_ch
);

  lrka_pkg::cfg_t                  cfg;
  lrka_pkg::state_t                state_r, state_nxt;
  lrka_pkg::op_t                   in_op;
  lrka_pkg::op_t                   op_r;
  lrka_pkg::mac_cmd_t              mac_cmd;

  logic [lrka_pkg::ADDR_W-1:0]     clr_addr_r;
  logic                            clr_item_r;
  logic [lrka_pkg::ADDR_W-1:0]     addr_r;
  logic [lrka_pkg::WORD_W-1:0]     sval_r;
  logic [lrka_pkg::WORD_W-1:0]     key_r;
  logic [lrka_pkg::LVL_W-1:0]      lvl_r;
  logic                            pend_status_r;
  logic [lrka_pkg::WORD_W-1:0]     pend_data_r;
  logic                            out_valid_r;
  logic                            out_status_r;
  logic [lrka_pkg::WORD_W-1:0]     out_data_r;

  logic                            in_accept;
  logic                            in_err;
  logic [lrka_pkg::ADDR_W-1:0]     in_addr;
  logic                            out_load;
  logic                            ram_en;
  logic                            ram_we;
  logic [lrka_pkg::ADDR_W-1:0]     ram_addr;
  logic [lrka_pkg::WORD_W-1:0]     ram_wdata;
  logic [lrka_pkg::WORD_W-1:0]     ram_rdata;
  logic [lrka_pkg::WORD_W-1:0]     mac_acc;
  logic                            mac_busy;

  lrka_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  lrka_ram #(
    .WIDTH (lrka_pkg::WORD_W),
    .DEPTH (lrka_pkg::STORE_WORDS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lrka_mac u_mac (
    .clk          (clk),
    .cmd          (mac_cmd),
    .base_bits    (cfg.base_bits),
    .levels       (cfg.levels),
    .sample_value (sval_r),
    .key_word     (key_r),
    .level        (lvl_r),
    .rdata        (ram_rdata),
    .acc          (mac_acc),
    .busy         (mac_busy)
  );

  assign in_op        = lrka_pkg::op_t'(in_ch.opcode);
  assign in_ch.ready  = (state_r == lrka_pkg::ST_IDLE);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.data_value = out_data_r;

  always_comb begin
    in_err = 1'b0;
    case (in_op)
      lrka_pkg::OP_CLEAR: in_err = 1'b0;
      lrka_pkg::OP_BODY_WR:
        in_err = (11'(in_ch.coef_index) >= cfg.used_coefficients) ||
                 (int'(in_ch.coef_index) >= lrka_pkg::RING_DEGREE) ||
                 (5'(in_ch.sample_slot) >= cfg.sample_count);
      lrka_pkg::OP_ACCUM:
        in_err = (11'(in_ch.mask_index) >= cfg.mask_length) ||
                 (5'(in_ch.sample_slot) >= cfg.sample_count) ||
                 (5'(in_ch.level) >= cfg.levels) ||
                 (int'(in_ch.coef_index) >= lrka_pkg::RING_DEGREE);
      lrka_pkg::OP_READ:
        in_err = (int'(in_ch.coef_index) >= lrka_pkg::RING_DEGREE);
      default: in_err = 1'b0;
    endcase
    in_addr = (in_op == lrka_pkg::OP_BODY_WR)
            ? lrka_pkg::word_addr(1'b1, in_ch.coef_index)
            : lrka_pkg::word_addr(in_ch.poly_index, in_ch.coef_index);
  end

  always_comb begin
    state_nxt = state_r;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = mac_acc;
    mac_cmd   = '0;
    out_load  = 1'b0;
    case (state_r)
      lrka_pkg::ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == lrka_pkg::ADDR_W'(lrka_pkg::STORE_WORDS - 1)) begin
          state_nxt = clr_item_r ? lrka_pkg::ST_DONE : lrka_pkg::ST_IDLE;
        end
      end
      lrka_pkg::ST_IDLE: begin
        ram_addr = in_addr;
        if (in_accept) begin
          case (in_op)
            lrka_pkg::OP_CLEAR: state_nxt = lrka_pkg::ST_CLEAR;
            lrka_pkg::OP_BODY_WR: begin
              ram_en    = !in_err;
              ram_we    = 1'b1;
              ram_wdata = in_ch.sample_value;
              state_nxt = lrka_pkg::ST_DONE;
            end
            default: begin
              // accumulate and read both fetch the addressed word first
              ram_en    = !in_err;
              state_nxt = in_err ? lrka_pkg::ST_DONE : lrka_pkg::ST_FETCH;
            end
          endcase
        end
      end
      lrka_pkg::ST_FETCH: begin
        mac_cmd.prep = 1'b1;
        state_nxt = (op_r == lrka_pkg::OP_ACCUM) ? lrka_pkg::ST_DIGIT
                                                 : lrka_pkg::ST_DONE;
      end
      lrka_pkg::ST_DIGIT: begin
        mac_cmd.load = 1'b1;
        state_nxt    = lrka_pkg::ST_MUL;
      end
      lrka_pkg::ST_MUL: begin
        if (mac_busy) begin
          mac_cmd.step = 1'b1;
        end else begin
          state_nxt = lrka_pkg::ST_WRITE;
        end
      end
      lrka_pkg::ST_WRITE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        state_nxt = lrka_pkg::ST_DONE;
      end
      lrka_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = lrka_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lrka_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrka_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == lrka_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end else if (in_accept) begin
        clr_addr_r <= '0;
        clr_item_r <= (in_op == lrka_pkg::OP_CLEAR);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r          <= in_op;
      addr_r        <= in_addr;
      sval_r        <= in_ch.sample_value;
      key_r         <= in_ch.key_word;
      lvl_r         <= in_ch.level;
      pend_status_r <= in_err;
      pend_data_r   <= (in_op == lrka_pkg::OP_BODY_WR && !in_err) ? in_ch.sample_value
                                                                   : '0;
    end else if (state_r == lrka_pkg::ST_FETCH && op_r == lrka_pkg::OP_READ) begin
      pend_data_r <= ram_rdata;
    end else if (state_r == lrka_pkg::ST_WRITE) begin
      pend_data_r <= mac_acc;
    end
    if (out_load) begin
      out_status_r <= pend_status_r;
      out_data_r   <= pend_data_r;
    end
  end

endmodule

`default_nettype wire

/* design/lrka_ram.sv */
`default_nettype none

module lrka_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/lrka_cfg.sv */
`default_nettype none

module lrka_cfg (
  input  wire logic     clk,
  input  wire logic     rst_n,
  lrka_cfg_if.sink      cfg_ch,
  output lrka_pkg::cfg_t cfg
);

  lrka_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_bits         <= 5'd2;
      cfg_r.levels            <= 5'd8;
      cfg_r.mask_length       <= 11'd1024;
      cfg_r.used_coefficients <= 11'd1024;
      cfg_r.sample_count      <= 5'd4;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (lrka_pkg::cfg_idx_t'(cfg_ch.index))
        lrka_pkg::CFG_BASE_BITS:    cfg_r.base_bits         <= cfg_ch.data[4:0];
        lrka_pkg::CFG_LEVELS:       cfg_r.levels            <= cfg_ch.data[4:0];
        lrka_pkg::CFG_MASK_LENGTH:  cfg_r.mask_length       <= cfg_ch.data[10:0];
        lrka_pkg::CFG_USED_COEFS:   cfg_r.used_coefficients <= cfg_ch.data[10:0];
        lrka_pkg::CFG_SAMPLE_COUNT: cfg_r.sample_count      <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* design/lrka_mac.sv */
`default_nettype none

// Shift-subtract unit: acc - digit * key, one digit bit per step.
module lrka_mac (
  input  wire logic                          clk,
  input  wire lrka_pkg::mac_cmd_t            cmd,
  input  wire logic [4:0]                    base_bits,
  input  wire logic [4:0]                    levels,
  input  wire logic [lrka_pkg::WORD_W-1:0]   sample_value,
  input  wire logic [lrka_pkg::WORD_W-1:0]   key_word,
  input  wire logic [lrka_pkg::LVL_W-1:0]    level,
  input  wire logic [lrka_pkg::WORD_W-1:0]   rdata,
  output logic      [lrka_pkg::WORD_W-1:0]   acc,
  output logic                               busy
);

  logic [9:0]                    bl_r;
  logic [8:0]                    lb_r;
  logic [lrka_pkg::WORD_W-1:0]   digit_r;
  logic [lrka_pkg::WORD_W-1:0]   key_r;
  logic [lrka_pkg::WORD_W-1:0]   acc_r;

  logic [lrka_pkg::WORD_W-1:0]   offset;
  logic [lrka_pkg::WORD_W-1:0]   rounded;
  logic [6:0]                    top_bit;
  logic [2*lrka_pkg::WORD_W-1:0] shifted;
  logic [lrka_pkg::WORD_W-1:0]   digit_mask;
  logic                          digit_zero;
  logic [lrka_pkg::WORD_W-1:0]   digit;

  always_comb begin
    offset     = (bl_r > 10'd31) ? '0 : (32'd1 << (5'd31 - bl_r[4:0]));
    rounded    = sample_value + offset;
    top_bit    = 7'(lb_r[5:0]) + 7'(base_bits);
    shifted    = {rounded, 32'd0} >> (7'd64 - top_bit);
    digit_mask = 32'((33'd1 << base_bits) - 33'd1);
    // digit lies entirely below the word when level*b reaches 32
    digit_zero = (base_bits == 5'd0) || (lb_r >= 9'd32);
    digit      = digit_zero ? '0 : (shifted[31:0] & digit_mask);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      bl_r <= 10'(base_bits) * 10'(levels);
      lb_r <= 9'(level) * 9'(base_bits);
    end
    if (cmd.load) begin
      digit_r <= digit;
      key_r   <= key_word;
      acc_r   <= rdata;
    end else if (cmd.step) begin
      if (digit_r[0]) begin
        acc_r <= acc_r - key_r;
      end
      key_r   <= key_r << 1;
      digit_r <= digit_r >> 1;
    end
  end

  assign acc  = acc_r;
  assign busy = (digit_r != '0);

endmodule

`default_nettype wire

/* design/lrka_chk.sv */
`default_nettype none

module lrka_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_status,
  input wire logic [lrka_pkg::WORD_W-1:0] out_data_value
);

  // one operation in flight: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // store sweep runs right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready during post-reset clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_data_value))
    else $error("stalled result changed");

  a_err_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_data_value == '0)
    else $error("error result carries nonzero data");

endmodule

bind lwe_to_rlwe_keyswitch_accumulator lrka_chk u_lrka_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_data_value (out_ch.data_value)
);

`default_nettype wire
